// ===== hdl/t16fd_pkg.sv =====
// Shared types, format codes and field-count table for the Thumb format decoder.
package t16fd_pkg;

  // Format numbers, in the usual order of the Thumb formats.
  typedef logic [4:0] fmt_t;

  localparam fmt_t FMT_UNDEF       = 5'd0;
  localparam fmt_t FMT_MOVE_SHIFT  = 5'd1;
  localparam fmt_t FMT_ADD_SUB     = 5'd2;
  localparam fmt_t FMT_IMM_OP      = 5'd3;
  localparam fmt_t FMT_ALU_OP      = 5'd4;
  localparam fmt_t FMT_HI_REG_BX   = 5'd5;
  localparam fmt_t FMT_PC_LOAD     = 5'd6;
  localparam fmt_t FMT_LDST_REG    = 5'd7;
  localparam fmt_t FMT_LDST_SIGN   = 5'd8;
  localparam fmt_t FMT_LDST_IMM    = 5'd9;
  localparam fmt_t FMT_LDST_HALF   = 5'd10;
  localparam fmt_t FMT_SP_LDST     = 5'd11;
  localparam fmt_t FMT_LOAD_ADDR   = 5'd12;
  localparam fmt_t FMT_SP_ADJUST   = 5'd13;
  localparam fmt_t FMT_PUSH_POP    = 5'd14;
  localparam fmt_t FMT_LDM_STM     = 5'd15;
  localparam fmt_t FMT_COND_BRANCH = 5'd16;
  localparam fmt_t FMT_SWI         = 5'd17;
  localparam fmt_t FMT_BRANCH      = 5'd18;
  localparam fmt_t FMT_LONG_BL     = 5'd19;

  // Classification handed from the classifier to the field slicer.
  typedef struct packed {
    fmt_t       fmt;
    logic [3:0] count;
  } t16fd_class_t;

  // Decoded fields, lowest first; unused slots are zero.
  typedef struct packed {
    logic [15:0] f0;
    logic [4:0]  f1;
    logic [4:0]  f2;
    logic [2:0]  f3;
    logic [2:0]  f4;
    logic [2:0]  f5;
    logic [2:0]  f6;
    logic [2:0]  f7;
  } t16fd_fields_t;

  // Number of fields that each format cuts the word into.
  function automatic logic [3:0] fmt_field_count(input fmt_t fmt);
    logic [3:0] n;
    n = 4'd1;
    unique case (fmt)
      FMT_MOVE_SHIFT, FMT_ALU_OP, FMT_SP_LDST,
      FMT_LOAD_ADDR, FMT_LDM_STM:                  n = 4'd5;
      FMT_ADD_SUB, FMT_HI_REG_BX:                  n = 4'd7;
      FMT_IMM_OP, FMT_PC_LOAD, FMT_SP_ADJUST,
      FMT_COND_BRANCH, FMT_LONG_BL:                n = 4'd4;
      FMT_LDST_REG, FMT_LDST_SIGN:                 n = 4'd8;
      FMT_LDST_IMM, FMT_LDST_HALF, FMT_PUSH_POP:   n = 4'd6;
      FMT_SWI, FMT_BRANCH:                         n = 4'd3;
      default:                                     n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/t16fd_classify.sv =====
// Format classifier: maps an instruction word to its Thumb format and field count.
module t16fd_classify import t16fd_pkg::*; (
  input  logic [15:0]  instr,
  output t16fd_class_t cls
);

  fmt_t fmt;

  // The top five bits pick the group; bits 11..8 settle the open groups.
  always_comb begin
    fmt = FMT_UNDEF;
    unique casez (instr[15:11])
      5'b000_00, 5'b000_01, 5'b000_10: fmt = FMT_MOVE_SHIFT;
      5'b000_11: fmt = FMT_ADD_SUB;
      5'b001_??: fmt = FMT_IMM_OP;
      5'b010_00: fmt = instr[10] ? FMT_HI_REG_BX : FMT_ALU_OP;
      5'b010_01: fmt = FMT_PC_LOAD;
      5'b010_1?: fmt = instr[9] ? FMT_LDST_SIGN : FMT_LDST_REG;
      5'b011_??: fmt = FMT_LDST_IMM;
      5'b100_0?: fmt = FMT_LDST_HALF;
      5'b100_1?: fmt = FMT_SP_LDST;
      5'b101_0?: fmt = FMT_LOAD_ADDR;
      5'b101_10: begin
        // Miscellaneous group: stack adjust, push/pop, anything else undefined.
        if (instr[11:8] == 4'b0000) begin
          fmt = FMT_SP_ADJUST;
        end else if (instr[10:9] == 2'b10) begin
          fmt = FMT_PUSH_POP;
        end else begin
          fmt = FMT_UNDEF;
        end
      end
      5'b101_11: fmt = FMT_PUSH_POP;
      5'b110_0?: fmt = FMT_LDM_STM;
      5'b110_10: fmt = FMT_COND_BRANCH;
      5'b110_11: fmt = (instr[11:8] == 4'b1111) ? FMT_SWI : FMT_COND_BRANCH;
      5'b111_00: fmt = FMT_BRANCH;
      5'b111_01: fmt = FMT_UNDEF;
      5'b111_1?: fmt = FMT_LONG_BL;
      default:   fmt = FMT_UNDEF;
    endcase
  end

  assign cls.fmt   = fmt;
  assign cls.count = fmt_field_count(fmt);

endmodule

// ===== hdl/t16fd_slice.sv =====
// Field slicer: cuts the instruction word into the fields of its format.
module t16fd_slice import t16fd_pkg::*; (
  input  logic [15:0]   instr,
  input  t16fd_class_t  cls,
  output t16fd_fields_t fields
);

  // Each format has a fixed layout from bit 0 upward; unused slots stay zero.
  always_comb begin
    fields = '0;
    unique case (cls.fmt)
      FMT_MOVE_SHIFT: begin
        fields.f0 = {13'd0, instr[2:0]};
        fields.f1 = {2'd0, instr[5:3]};
        fields.f2 = instr[10:6];
        fields.f3 = {1'b0, instr[12:11]};
        fields.f4 = instr[15:13];
      end
      FMT_ADD_SUB: begin
        fields.f0 = {13'd0, instr[2:0]};
        fields.f1 = {2'd0, instr[5:3]};
        fields.f2 = {2'd0, instr[8:6]};
        fields.f3 = {2'd0, instr[9]};
        fields.f4 = {2'd0, instr[10]};
        fields.f5 = {1'b0, instr[12:11]};
        fields.f6 = instr[15:13];
      end
      FMT_IMM_OP, FMT_PC_LOAD, FMT_SP_ADJUST: begin
        fields.f0 = {8'd0, instr[7:0]};
        fields.f1 = {2'd0, instr[10:8]};
        fields.f2 = {3'd0, instr[12:11]};
        fields.f3 = instr[15:13];
      end
      FMT_ALU_OP: begin
        fields.f0 = {13'd0, instr[2:0]};
        fields.f1 = {2'd0, instr[5:3]};
        fields.f2 = {1'b0, instr[9:6]};
        fields.f3 = instr[12:10];
        fields.f4 = instr[15:13];
      end
      FMT_HI_REG_BX: begin
        fields.f0 = {13'd0, instr[2:0]};
        fields.f1 = {2'd0, instr[5:3]};
        fields.f2 = {4'd0, instr[6]};
        fields.f3 = {2'd0, instr[7]};
        fields.f4 = {1'b0, instr[9:8]};
        fields.f5 = instr[12:10];
        fields.f6 = instr[15:13];
      end
      FMT_LDST_REG, FMT_LDST_SIGN: begin
        fields.f0 = {13'd0, instr[2:0]};
        fields.f1 = {2'd0, instr[5:3]};
        fields.f2 = {2'd0, instr[8:6]};
        fields.f3 = {2'd0, instr[9]};
        fields.f4 = {2'd0, instr[10]};
        fields.f5 = {2'd0, instr[11]};
        fields.f6 = {2'd0, instr[12]};
        fields.f7 = instr[15:13];
      end
      FMT_LDST_IMM, FMT_LDST_HALF: begin
        fields.f0 = {13'd0, instr[2:0]};
        fields.f1 = {2'd0, instr[5:3]};
        fields.f2 = instr[10:6];
        fields.f3 = {2'd0, instr[11]};
        fields.f4 = {2'd0, instr[12]};
        fields.f5 = instr[15:13];
      end
      FMT_SP_LDST, FMT_LOAD_ADDR, FMT_LDM_STM: begin
        fields.f0 = {8'd0, instr[7:0]};
        fields.f1 = {2'd0, instr[10:8]};
        fields.f2 = {4'd0, instr[11]};
        fields.f3 = {2'd0, instr[12]};
        fields.f4 = instr[15:13];
      end
      FMT_PUSH_POP: begin
        fields.f0 = {8'd0, instr[7:0]};
        fields.f1 = {4'd0, instr[8]};
        fields.f2 = {3'd0, instr[10:9]};
        fields.f3 = {2'd0, instr[11]};
        fields.f4 = {2'd0, instr[12]};
        fields.f5 = instr[15:13];
      end
      FMT_COND_BRANCH: begin
        fields.f0 = {8'd0, instr[7:0]};
        fields.f1 = {1'b0, instr[11:8]};
        fields.f2 = {4'd0, instr[12]};
        fields.f3 = instr[15:13];
      end
      FMT_SWI: begin
        fields.f0 = {8'd0, instr[7:0]};
        fields.f1 = instr[12:8];
        fields.f2 = {2'd0, instr[15:13]};
      end
      FMT_BRANCH: begin
        fields.f0 = {5'd0, instr[10:0]};
        fields.f1 = {3'd0, instr[12:11]};
        fields.f2 = {2'd0, instr[15:13]};
      end
      FMT_LONG_BL: begin
        fields.f0 = {5'd0, instr[10:0]};
        fields.f1 = {4'd0, instr[11]};
        fields.f2 = {4'd0, instr[12]};
        fields.f3 = instr[15:13];
      end
      default: begin
        // Undefined word: the whole word is the only field.
        fields.f0 = instr;
      end
    endcase
  end

endmodule

// ===== hdl/thumb16_format_field_decoder_top.sv =====
// Top level of the Thumb 16-bit instruction format and field decoder.
//
//   Channel  Ports                                   Handshake
//   request  start, busy, in_instr                   taken when start && !busy
//   result   out_valid, out_format_type,             one-cycle strobe, no back-pressure
//            out_field_count, out_field0..7
//
// One request is taken every clock cycle; busy is never raised.
// A request passes through the input register, the decode and the result register before its result appears.
// The decode is a single pass through the classifier and the field slicer.
// Reset (rst_n low, synchronous) clears the valid flags; data registers are not reset.
// The receiver cannot stall, so no result is ever held back.
module thumb16_format_field_decoder_top import t16fd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_instr,
  output logic        out_valid,
  output logic [4:0]  out_format_type,
  output logic [3:0]  out_field_count,
  output logic [15:0] out_field0,
  output logic [4:0]  out_field1,
  output logic [4:0]  out_field2,
  output logic [2:0]  out_field3,
  output logic [2:0]  out_field4,
  output logic [2:0]  out_field5,
  output logic [2:0]  out_field6,
  output logic [2:0]  out_field7
);

  logic          in_valid_r;
  logic          in_valid_nxt;
  logic [15:0]   instr_r;
  logic          out_valid_r;
  t16fd_class_t  cls;
  t16fd_fields_t fields;
  t16fd_class_t  cls_r;
  t16fd_fields_t fields_r;

  // The decoder never stalls a request.
  assign busy         = 1'b0;
  assign in_valid_nxt = start && !busy;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      instr_r <= in_instr;
    end
  end

  // Single decode pass between the two registers.
  t16fd_classify u_classify (
    .instr (instr_r),
    .cls   (cls)
  );

  t16fd_slice u_slice (
    .instr  (instr_r),
    .cls    (cls),
    .fields (fields)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      cls_r    <= cls;
      fields_r <= fields;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_format_type = cls_r.fmt;
  assign out_field_count = cls_r.count;
  assign out_field0      = fields_r.f0;
  assign out_field1      = fields_r.f1;
  assign out_field2      = fields_r.f2;
  assign out_field3      = fields_r.f3;
  assign out_field4      = fields_r.f4;
  assign out_field5      = fields_r.f5;
  assign out_field6      = fields_r.f6;
  assign out_field7      = fields_r.f7;

  // Every request yields a result after passing the input and result registers.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("request did not produce a result two cycles later");

  // A result strobe needs the input register to have held a valid request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r))
    else $error("result strobe without a pending request");

  // The field count stays within one to eight.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_field_count != 4'd0) && (out_field_count <= 4'd8))
    else $error("field count out of range");

  // An undefined word has a single field and nothing in the upper slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_format_type == FMT_UNDEF) |->
      (out_field_count == 4'd1) && (out_field1 == 5'd0) && (out_field7 == 3'd0))
    else $error("undefined word decoded with extra fields");

endmodule
